@@ rtl/core/lvs3d_pkg.sv @@
// Shared types, widths and helper functions of the 3D voxel line stepper.
`default_nettype none

package lvs3d_pkg;

  // Largest span per axis. Offsets beyond it saturate to it.
  localparam int MAX_SPAN    = 63;
  localparam int COORD_W     = 7;
  localparam int SPAN_W      = 6;
  localparam int ERR_W       = 8;
  localparam int NUM_AXES    = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic signed [COORD_W-1:0] SPAN_HI = COORD_W'(MAX_SPAN);
  localparam logic signed [COORD_W-1:0] SPAN_LO = -SPAN_HI;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [SPAN_W-1:0]  span_t;
  typedef logic signed [ERR_W-1:0]   err_t;

  // One classified line, ready for the stepper.
  typedef struct packed {
    logic [NUM_AXES-1:0] major_oh;   // one-hot dominant axis
    logic [NUM_AXES-1:0] neg;        // axis steps toward minus
    span_t               span_x;
    span_t               span_y;
    span_t               span_z;
    span_t               span_major;
    err_t                err_x;
    err_t                err_y;
    err_t                err_z;
  } job_t;

  // Stepper status, watched at the top level.
  typedef struct packed {
    logic  active;
    span_t remaining;
  } back_status_t;

  function automatic coord_t clamp_coord(input coord_t v);
    coord_t r;
    if (v > SPAN_HI) begin
      r = SPAN_HI;
    end else if (v < SPAN_LO) begin
      r = SPAN_LO;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic span_t abs_span(input coord_t v);
    coord_t a;
    a = (v < 0) ? -v : v;
    return a[SPAN_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/lvs3d_if.sv @@
// Handshake channel interfaces for offsets in and voxel points out.
`default_nettype none

interface lvs3d_in_if;
  logic                     valid;
  logic                     ready;
  logic signed [6:0]        delta_x;
  logic signed [6:0]        delta_y;
  logic signed [6:0]        delta_z;

  modport source (output valid, output delta_x, output delta_y, output delta_z,
                  input ready);
  modport sink   (input valid, input delta_x, input delta_y, input delta_z,
                  output ready);
endinterface

interface lvs3d_out_if;
  logic                     valid;
  logic                     ready;
  logic signed [6:0]        point_x;
  logic signed [6:0]        point_y;
  logic signed [6:0]        point_z;
  logic                     last_point;

  modport source (output valid, output point_x, output point_y, output point_z,
                  output last_point, input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z,
                  input last_point, output ready);
endinterface

`default_nettype wire

@@ rtl/core/line_voxel_stepper_3d_unit.sv @@
// Top level of the 3D Bresenham voxel line stepper.
//
//   channel  direction  payload                                   item
//   in_i     sink       delta_x, delta_y, delta_z (7b signed)     one end offset
//   out_o    source     point_x, point_y, point_z (7b signed),    one voxel point
//                       last_point
//
// A line whose dominant span is S (0 to 63) gives S+1 points: the stepper registers
// the origin as it loads the item and then one point per cycle unless out_o stalls.
// Between lines there is no gap while the job queue holds the next item.
// Reset is asynchronous and active low; it empties the queue and the output
// stage, and no clearing pass follows it.
// A stall on out_o freezes the stepper; the front end keeps taking items until
// the two-entry queue is full.
`default_nettype none

module line_voxel_stepper_3d_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  lvs3d_in_if.sink    in_i,
  lvs3d_out_if.source out_o
);
  import lvs3d_pkg::*;

  job_t         fr_job;
  logic         fr_valid, fr_ready;
  job_t         q_job;
  logic         q_valid, q_ready;
  back_status_t bk_status;

  // The front end classifies each offset as it is accepted.
  lvs3d_front u_front (
    .in_i        (in_i),
    .job_o       (fr_job),
    .job_valid_o (fr_valid),
    .job_ready_i (fr_ready)
  );

  // The queue lets the front end run ahead of a stalled stepper.
  lvs3d_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_data_i  (fr_job),
    .wr_ready_o (fr_ready),
    .rd_valid_o (q_valid),
    .rd_data_o  (q_job),
    .rd_ready_i (q_ready)
  );

  // The stepper walks the line and owns the output register.
  lvs3d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (q_job),
    .job_valid_i (q_valid),
    .job_ready_o (q_ready),
    .out_o       (out_o),
    .status_o    (bk_status)
  );

  // While a line is in progress there are always points left to walk.
  a_active_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_status.active |-> (bk_status.remaining != '0))
    else $error("stepper active with no points left");

  // A point that is not the last one means its line is still in progress.
  a_mid_point_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.last_point) |-> bk_status.active)
    else $error("non-final point shown with the stepper idle");

  // An accepted item is held somewhere in the block on the next cycle.
  a_item_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (q_valid || bk_status.active || out_o.valid))
    else $error("accepted item vanished");

  // The stepper loads a new line only when it is idle.
  a_load_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && q_ready) |-> !bk_status.active)
    else $error("line loaded while another is in progress");

endmodule

`default_nettype wire

@@ rtl/core/lvs3d_front.sv @@
// Front end: saturates an offset, picks the dominant axis and sets up the error terms.
`default_nettype none

module lvs3d_front (
  lvs3d_in_if.sink        in_i,
  output lvs3d_pkg::job_t job_o,
  output logic            job_valid_o,
  input  logic            job_ready_i
);
  import lvs3d_pkg::*;

  coord_t end_x, end_y, end_z;
  span_t  sx, sy, sz, smaj;
  logic [NUM_AXES-1:0] major_oh;

  function automatic err_t init_err(input span_t s_min, input span_t s_maj);
    logic signed [ERR_W:0] e;
    e = $signed({2'b00, s_min, 1'b0}) - $signed({3'b000, s_maj});
    return e[ERR_W-1:0];
  endfunction

  always_comb begin
    end_x = clamp_coord(in_i.delta_x);
    end_y = clamp_coord(in_i.delta_y);
    end_z = clamp_coord(in_i.delta_z);
    sx    = abs_span(end_x);
    sy    = abs_span(end_y);
    sz    = abs_span(end_z);

    // Ties go to x first, then to y.
    if (sx >= sy && sx >= sz) begin
      major_oh = 3'b001;
      smaj     = sx;
    end else if (sy >= sz) begin
      major_oh = 3'b010;
      smaj     = sy;
    end else begin
      major_oh = 3'b100;
      smaj     = sz;
    end

    job_o.major_oh   = major_oh;
    job_o.neg        = {!(end_z > 0), !(end_y > 0), !(end_x > 0)};
    job_o.span_x     = sx;
    job_o.span_y     = sy;
    job_o.span_z     = sz;
    job_o.span_major = smaj;
    job_o.err_x      = init_err(sx, smaj);
    job_o.err_y      = init_err(sy, smaj);
    job_o.err_z      = init_err(sz, smaj);
  end

  assign job_valid_o = in_i.valid;
  assign in_i.ready  = job_ready_i;

endmodule

`default_nettype wire

@@ rtl/core/lvs3d_queue.sv @@
// Short job queue that decouples the front end from the stepper.
`default_nettype none

module lvs3d_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  input  lvs3d_pkg::job_t wr_data_i,
  output logic            wr_ready_o,
  output logic            rd_valid_o,
  output lvs3d_pkg::job_t rd_data_o,
  input  logic            rd_ready_i
);
  import lvs3d_pkg::*;

  job_t                entry_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CW-1:0] count_q, count_d;
  logic                push, pop;

  assign wr_ready_o = (count_q != QUEUE_CW'(QUEUE_DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = entry_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/lvs3d_back.sv @@
// Stepper: walks one line a point per cycle unless out_o stalls, into a registered output stage.
`default_nettype none

module lvs3d_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lvs3d_pkg::job_t         job_i,
  input  logic                    job_valid_i,
  output logic                    job_ready_o,
  lvs3d_out_if.source             out_o,
  output lvs3d_pkg::back_status_t status_o
);
  import lvs3d_pkg::*;

  logic                active_q, active_d;
  span_t               remaining_q, remaining_d;
  logic [NUM_AXES-1:0] major_q, neg_q;
  span_t               span_q   [NUM_AXES];
  span_t               smaj_q;
  err_t                err_q    [NUM_AXES];
  err_t                err_nx   [NUM_AXES];
  coord_t              pos_q    [NUM_AXES];
  coord_t              pos_nx   [NUM_AXES];

  logic                out_valid_q, out_valid_d;
  coord_t              out_pt_q [NUM_AXES];
  logic                out_last_q;

  logic                can_emit, load, step;

  assign can_emit    = !out_valid_q || out_o.ready;
  assign load        = !active_q && job_valid_i && can_emit;
  assign step        = active_q && can_emit;
  assign job_ready_o = load;

  // One Bresenham step on every axis at once.
  always_comb begin
    logic signed [ERR_W:0] e;
    logic                  move;
    for (int j = 0; j < NUM_AXES; j++) begin
      move = major_q[j] || (err_q[j] >= 0);
      e    = {err_q[j][ERR_W-1], err_q[j]} + $signed({2'b00, span_q[j], 1'b0});
      if (!major_q[j] && err_q[j] >= 0) begin
        e = e - $signed({2'b00, smaj_q, 1'b0});
      end
      err_nx[j] = e[ERR_W-1:0];
      pos_nx[j] = move ? (neg_q[j] ? pos_q[j] - 1'b1 : pos_q[j] + 1'b1) : pos_q[j];
    end
  end

  always_comb begin
    active_d    = active_q;
    remaining_d = remaining_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if (load) begin
      active_d    = (job_i.span_major != '0);
      remaining_d = job_i.span_major;
      out_valid_d = 1'b1;
    end else if (step) begin
      active_d    = (remaining_q != SPAN_W'(1));
      remaining_d = remaining_q - 1'b1;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      remaining_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      remaining_q <= remaining_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      major_q    <= job_i.major_oh;
      neg_q      <= job_i.neg;
      smaj_q     <= job_i.span_major;
      span_q[0]  <= job_i.span_x;
      span_q[1]  <= job_i.span_y;
      span_q[2]  <= job_i.span_z;
      err_q[0]   <= job_i.err_x;
      err_q[1]   <= job_i.err_y;
      err_q[2]   <= job_i.err_z;
      for (int j = 0; j < NUM_AXES; j++) begin
        pos_q[j]    <= '0;
        out_pt_q[j] <= '0;
      end
      out_last_q <= (job_i.span_major == '0);
    end else if (step) begin
      for (int j = 0; j < NUM_AXES; j++) begin
        pos_q[j]    <= pos_nx[j];
        err_q[j]    <= err_nx[j];
        out_pt_q[j] <= pos_nx[j];
      end
      out_last_q <= (remaining_q == SPAN_W'(1));
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.point_x    = out_pt_q[0];
  assign out_o.point_y    = out_pt_q[1];
  assign out_o.point_z    = out_pt_q[2];
  assign out_o.last_point = out_last_q;

  assign status_o.active    = active_q;
  assign status_o.remaining = remaining_q;

endmodule

`default_nettype wire
